// ===== rtl/sbmd_pkg.sv =====
// Shared types and constants for the signed Booth multiply / restoring divide ALU.
// No dependencies.
`default_nettype none
package sbmd_pkg;

    localparam int WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_DIV_OVF = 2'd2
    } t_status;

    // control that rides along with each beat through the chain
    typedef struct packed {
        logic    valid;
        t_op     op;
        logic    neg_q;
        logic    neg_r;
        logic    ovf;
        t_status status;
    } t_ctrl;

endpackage
`default_nettype wire

// ===== rtl/sbmd_prep.sv =====
// Entry stage: add/sub result, Booth and divider operand setup.
// Depends on sbmd_pkg.
`default_nettype none
module sbmd_prep
    import sbmd_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [1:0]              i_operation,
    input  wire logic [WIDTH-1:0]        i_a,
    input  wire logic [WIDTH-1:0]        i_b,
    output t_ctrl                        o_ctrl,
    output logic      [WIDTH:0]          o_hi,
    output logic      [WIDTH-1:0]        o_lo,
    output logic      [WIDTH-1:0]        o_m,
    output logic                         o_qm1
);

    t_ctrl            r_ctrl, n_ctrl;
    logic [WIDTH:0]   r_hi, n_hi;
    logic [WIDTH-1:0] r_lo, n_lo, r_m, n_m;
    logic [WIDTH-1:0] sum, negb, abs_a, abs_b;
    logic             sa, sb;

    always_comb begin
        sa     = i_a[WIDTH-1];
        sb     = i_b[WIDTH-1];
        negb   = ~i_b + {{(WIDTH-1){1'b0}}, 1'b1};
        abs_a  = sa ? (~i_a + {{(WIDTH-1){1'b0}}, 1'b1}) : i_a;
        abs_b  = sb ? negb : i_b;
        sum    = '0;
        n_ctrl = '0;
        n_ctrl.valid = i_valid;
        n_ctrl.op    = t_op'(i_operation);
        n_hi   = '0;
        n_lo   = '0;
        n_m    = '0;
        unique case (t_op'(i_operation))
            OP_ADD: begin
                sum  = i_a + i_b;
                n_lo = sum;
                n_ctrl.ovf = (sa == sb) && (sum[WIDTH-1] != sa);
            end
            OP_SUB: begin
                sum  = i_a + negb;
                n_lo = sum;
                n_ctrl.ovf = (sa != sb) && (sum[WIDTH-1] != sa);
            end
            OP_MUL: begin
                n_lo = i_b;
                n_m  = i_a;
            end
            OP_DIV: begin
                n_lo = abs_a;
                n_m  = abs_b;
                n_ctrl.neg_q = sa ^ sb;
                n_ctrl.neg_r = sa;
                if (i_b == '0) begin
                    n_ctrl.status = ST_DIV_ZERO;
                end else if (i_a == {1'b1, {(WIDTH-1){1'b0}}} && i_b == '1) begin
                    n_ctrl.status = ST_DIV_OVF;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
            r_m  <= n_m;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;
    assign o_m    = r_m;
    assign o_qm1  = 1'b0;

endmodule
`default_nettype wire

// ===== rtl/sbmd_cell.sv =====
// One step cell: a Booth recode/shift step or a restoring division step.
// Depends on sbmd_pkg.
`default_nettype none
module sbmd_cell
    import sbmd_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire t_ctrl           i_ctrl,
    input  wire logic [WIDTH:0]  i_hi,
    input  wire logic [WIDTH-1:0] i_lo,
    input  wire logic [WIDTH-1:0] i_m,
    input  wire logic            i_qm1,
    output t_ctrl                o_ctrl,
    output logic      [WIDTH:0]  o_hi,
    output logic      [WIDTH-1:0] o_lo,
    output logic      [WIDTH-1:0] o_m,
    output logic                 o_qm1
);

    t_ctrl            r_ctrl;
    logic [WIDTH:0]   r_hi, n_hi, acc, mx, rs, diff;
    logic [WIDTH-1:0] r_lo, n_lo, r_m;
    logic             r_qm1, n_qm1;

    always_comb begin
        mx    = {i_m[WIDTH-1], i_m};
        acc   = i_hi;
        rs    = {i_hi[WIDTH-1:0], i_lo[WIDTH-1]};
        diff  = rs - {1'b0, i_m};
        n_hi  = i_hi;
        n_lo  = i_lo;
        n_qm1 = i_qm1;
        unique case (i_ctrl.op)
            OP_MUL: begin
                unique case ({i_lo[0], i_qm1})
                    2'b01:   acc = i_hi + mx;
                    2'b10:   acc = i_hi - mx;
                    default: acc = i_hi;
                endcase
                n_hi  = {acc[WIDTH], acc[WIDTH:1]};
                n_lo  = {acc[0], i_lo[WIDTH-1:1]};
                n_qm1 = i_lo[0];
            end
            OP_DIV: begin
                if (!diff[WIDTH]) begin
                    n_hi = diff;
                    n_lo = {i_lo[WIDTH-2:0], 1'b1};
                end else begin
                    n_hi = rs;
                    n_lo = {i_lo[WIDTH-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi  <= n_hi;
            r_lo  <= n_lo;
            r_m   <= i_m;
            r_qm1 <= n_qm1;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;
    assign o_m    = r_m;
    assign o_qm1  = r_qm1;

endmodule
`default_nettype wire

// ===== rtl/signed_booth_mul_restoring_div_alu.sv =====
// Structure: entry stage, WIDTH step cells and an output reg, WIDTH+2 registers in all, the
// first loaded at the accepting edge.
// Throughput: one beat per cycle; the whole chain advances together and holds while a
// finished result is stalled at the output register.
// Reset: synchronous active-low i_rst_n clears every stage's valid bit; data is not reset.
// Depends on sbmd_pkg, sbmd_prep, sbmd_cell.
`default_nettype none
module signed_booth_mul_restoring_div_alu
    import sbmd_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic        [1:0]       i_operation,
    input  wire logic signed [WIDTH-1:0] i_operand_a,
    input  wire logic signed [WIDTH-1:0] i_operand_b,
    // result channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [WIDTH-1:0]      o_result_low,
    output logic signed [WIDTH-1:0]      o_result_high,
    output logic                         o_overflow,
    output logic        [1:0]            o_status
);

    // chain advances whenever the output register is free or being drained
    logic advance;

    t_ctrl            w_ctrl [0:WIDTH];
    logic [WIDTH:0]   w_hi   [0:WIDTH];
    logic [WIDTH-1:0] w_lo   [0:WIDTH];
    logic [WIDTH-1:0] w_m    [0:WIDTH];
    logic             w_qm1  [0:WIDTH];

    logic             r_out_valid;
    logic [WIDTH-1:0] r_lo, n_lo, r_hi, n_hi;
    logic             r_ovf;
    t_status          r_status;
    logic [WIDTH-1:0] rem;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = !advance;

    sbmd_prep #(.WIDTH(WIDTH)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_a         (i_operand_a),
        .i_b         (i_operand_b),
        .o_ctrl      (w_ctrl[0]),
        .o_hi        (w_hi[0]),
        .o_lo        (w_lo[0]),
        .o_m         (w_m[0]),
        .o_qm1       (w_qm1[0])
    );

    // one cell per Booth step / quotient bit
    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        sbmd_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_ctrl  (w_ctrl[g]),
            .i_hi    (w_hi[g]),
            .i_lo    (w_lo[g]),
            .i_m     (w_m[g]),
            .i_qm1   (w_qm1[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_hi    (w_hi[g+1]),
            .o_lo    (w_lo[g+1]),
            .o_m     (w_m[g+1]),
            .o_qm1   (w_qm1[g+1])
        );
    end

    // final sign fix-up and result selection
    always_comb begin
        rem  = w_hi[WIDTH][WIDTH-1:0];
        n_lo = w_lo[WIDTH];
        n_hi = '0;
        unique case (w_ctrl[WIDTH].op)
            OP_MUL: begin
                n_hi = rem;
            end
            OP_DIV: begin
                if (w_ctrl[WIDTH].status != ST_OK) begin
                    n_lo = '0;
                end else begin
                    n_lo = w_ctrl[WIDTH].neg_q ? (~w_lo[WIDTH] + {{(WIDTH-1){1'b0}}, 1'b1})
                                               : w_lo[WIDTH];
                    n_hi = w_ctrl[WIDTH].neg_r ? (~rem + {{(WIDTH-1){1'b0}}, 1'b1}) : rem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= w_ctrl[WIDTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_ovf    <= w_ctrl[WIDTH].ovf;
            r_status <= w_ctrl[WIDTH].status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_low  = r_lo;
    assign o_result_high = r_hi;
    assign o_overflow    = r_ovf;
    assign o_status      = r_status;

    // error status beats carry zero results
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_result_low == '0 && o_result_high == '0))
        else $error("error beat with nonzero result");

    // overflow only comes from add/sub, which never set status or the high half
    a_ovf_addsub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_status == ST_OK && o_result_high == '0))
        else $error("overflow on a non add/sub beat");

    // input is held off only when a finished result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled without a waiting result");

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_low) && $stable(o_result_high)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
